### sv/ovl_pkg.sv
package ovl_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int OUT_CNT_W = 5;

    typedef logic [OP_W-1:0]        t_opcode;
    typedef logic [ST_W-1:0]        t_status;
    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]       t_count;

    localparam t_opcode OP_APPEND  = 2'd0;
    localparam t_opcode OP_REPLACE = 2'd1;
    localparam t_opcode OP_ERASE   = 2'd2;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_NOMATCH = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### sv/ovl_if.sv
interface ovl_req_if import ovl_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_word   operand_value;
    t_word   replacement;

    modport source (output valid, opcode, operand_value, replacement, input ready);
    modport sink   (input valid, opcode, operand_value, replacement, output ready);
endinterface

interface ovl_rsp_if import ovl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, status, entry_count, input ready);
    modport sink   (input valid, status, entry_count, output ready);
endinterface

### sv/ordered_value_list_top.sv
// Ordered value list: holds up to DEPTH signed words in insertion order.
// Requests arrive on i_req (opcode, operand_value, replacement) and each
// produces exactly one response on o_rsp (status, entry_count), both with
// valid/ready handshakes. Append adds the value at the tail, or reports
// full. Replace overwrites the first entry from the front equal to the key.
// Erase removes the front entry if it matches, else the tail entry if it
// matches, else the first match, and the entries behind it close up.
// A request is taken by a row of cells that compare the key
// in parallel and shift towards the front; its response is registered
// and is shown the cycle after acceptance. One request per cycle is
// sustained while responses are being taken.
// If the receiver stalls, the response is held and a new request is only
// taken in the cycle in which the held response is taken.
// Reset empties the list and drops any pending response; i_req.ready is
// low while reset is asserted.
module ordered_value_list_top import ovl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ovl_req_if.sink   i_req,
    ovl_rsp_if.source o_rsp
);

    logic                 w_accept;
    logic [DEPTH-1:0]     w_live;
    logic [DEPTH-1:0]     w_match;
    t_cell_ctl            w_ctl [DEPTH];
    t_word                w_value [DEPTH];
    t_word                w_load_data;
    t_status              w_status;
    t_count               w_count_next;

    logic                 r_rsp_valid;
    t_status              r_status;
    logic [OUT_CNT_W-1:0] r_entry_count;
    logic                 n_rsp_valid;

    assign i_req.ready = i_rst_n && (!r_rsp_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_data = (i_req.opcode == OP_APPEND) ? i_req.operand_value
                                                     : i_req.replacement;

    ovl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_opcode     (i_req.opcode),
        .i_match      (w_match),
        .o_live       (w_live),
        .o_ctl        (w_ctl),
        .o_status     (w_status),
        .o_count_next (w_count_next)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_value[g];
        end else begin : g_mid
            assign w_next = w_value[g+1];
        end

        ovl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_live      (w_live[g]),
            .i_key       (i_req.operand_value),
            .i_load_data (w_load_data),
            .i_next      (w_next),
            .o_value     (w_value[g]),
            .o_match     (w_match[g])
        );
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (w_accept) begin
            n_rsp_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_status;
            r_entry_count <= OUT_CNT_W'(w_count_next);
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

endmodule

### sv/ovl_cell.sv
module ovl_cell import ovl_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_live,
    input  t_word     i_key,
    input  t_word     i_load_data,
    input  t_word     i_next,
    output t_word     o_value,
    output logic      o_match
);

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_load_data;
        end else if (i_ctl.shift) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = i_live && (r_value == i_key);

endmodule

### sv/ovl_ctrl.sv
module ovl_ctrl import ovl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_opcode          i_opcode,
    input  logic [DEPTH-1:0] i_match,
    output logic [DEPTH-1:0] o_live,
    output t_cell_ctl        o_ctl [DEPTH],
    output t_status          o_status,
    output t_count           o_count_next
);

    t_count           r_count;
    t_count           n_count;
    t_status          w_status;
    logic [DEPTH-1:0] w_live;
    logic [DEPTH-1:0] w_first_oh;
    logic [DEPTH-1:0] w_tail_oh;
    logic [DEPTH-1:0] w_erase_oh;
    logic [DEPTH-1:0] w_shift_mask;
    logic [DEPTH-1:0] w_append_oh;
    logic [DEPTH-1:0] w_load;
    logic [DEPTH-1:0] w_shift;
    logic             w_tail_hit;
    logic             w_any_match;
    logic             w_full;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_live[i] = CNT_W'(i) < r_count;
        end
    end

    assign w_any_match  = |i_match;
    assign w_full       = (r_count == CNT_W'(DEPTH));
    assign w_first_oh   = i_match & (~i_match + DEPTH'(1));
    assign w_tail_oh    = w_live & ~(w_live >> 1);
    assign w_tail_hit   = |(i_match & w_tail_oh);
    assign w_erase_oh   = (w_tail_hit && !i_match[0]) ? w_tail_oh : w_first_oh;
    assign w_shift_mask = ~(w_erase_oh - DEPTH'(1));
    assign w_append_oh  = {w_live[DEPTH-2:0], 1'b1} & ~w_live;

    always_comb begin
        n_count  = r_count;
        w_status = ST_NOMATCH;
        w_load   = '0;
        w_shift  = '0;
        case (i_opcode)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_DONE;
                    w_load   = w_append_oh;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_REPLACE: begin
                if (w_any_match) begin
                    w_status = ST_DONE;
                    w_load   = w_first_oh;
                end
            end
            OP_ERASE: begin
                if (w_any_match) begin
                    w_status = ST_DONE;
                    w_shift  = w_shift_mask;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = ST_NOMATCH;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_ctl[i].load  = i_accept && w_load[i];
            o_ctl[i].shift = i_accept && w_shift[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_live       = w_live;
    assign o_status     = w_status;
    assign o_count_next = n_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("live count exceeds the list depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_count))
        else $error("live count changed without a request");

    a_erase_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_opcode == OP_ERASE) && w_any_match
        |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("erase did not remove exactly one entry");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status == ST_FULL) |-> w_full && (i_opcode == OP_APPEND))
        else $error("full status reported on a list with room");
`endif

endmodule
